>>> sv/trc_pkg.sv
// Package for the threshold relay controller: types, codes and fixed constants.
package trc_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [2:0] {
    OP_MENU   = 3'd0,
    OP_UP     = 3'd1,
    OP_DOWN   = 3'd2,
    OP_PUMP   = 3'd3,
    OP_SAMPLE = 3'd4
  } op_e;

  // Menu positions
  localparam logic [2:0] MENU_RUN   = 3'd0;
  localparam logic [2:0] MENU_MOIST = 3'd1;
  localparam logic [2:0] MENU_TEMP  = 3'd2;
  localparam logic [2:0] MENU_LIGHT = 3'd3;
  localparam logic [2:0] MENU_CO2   = 3'd4;
  localparam logic [2:0] MENU_MODE  = 3'd5;

  // Limits and conversion constants
  localparam logic [6:0]  PCT_MAX       = 7'd99;
  localparam logic [12:0] CO2_CAP       = 13'd5000;
  localparam logic [12:0] CO2_STEP      = 13'd10;
  localparam logic [11:0] SOIL_DRY_EDGE = 12'd1241;
  localparam logic [6:0]  LIGHT_GAIN    = 7'd99;
  localparam logic [11:0] SOIL_GAIN     = 12'd2296;
  localparam logic [12:0] ADC_FULL      = 13'd4096;

  // One input request
  typedef struct packed {
    op_e         op;
    logic [11:0] light_adc;
    logic [11:0] soil_adc;
    logic [7:0]  temp_deg;
    logic        co2_valid;
    logic [13:0] co2_reading;
  } item_t;

  // Converted readings of a sample tick
  typedef struct packed {
    logic [6:0]  light_pct;
    logic [6:0]  soil_pct;
    logic [7:0]  temp_deg;
    logic        co2_valid;
    logic [12:0] co2_ppm;
  } sample_t;

  // Controller state
  typedef struct packed {
    logic [2:0]  menu_pos;
    logic        manual_flag;
    logic [6:0]  moisture_sp;
    logic [6:0]  temp_sp;
    logic [6:0]  light_sp;
    logic [12:0] co2_limit;
    logic        lamp;
    logic        fan;
    logic        pump;
    logic        buzzer;
    logic [6:0]  light_stored;
    logic [6:0]  soil_stored;
    logic [12:0] co2_stored;
  } ctrl_state_t;

  localparam ctrl_state_t STATE_RESET = '{
    menu_pos:     MENU_RUN,
    manual_flag:  1'b0,
    moisture_sp:  7'd10,
    temp_sp:      7'd35,
    light_sp:     7'd20,
    co2_limit:    13'd2000,
    lamp:         1'b0,
    fan:          1'b0,
    pump:         1'b0,
    buzzer:       1'b0,
    light_stored: 7'd0,
    soil_stored:  7'd0,
    co2_stored:   13'd0
  };

  // Result word, packed from the lowest bit up as lamp, fan, pump, buzzer,
  // menu_position, manual_mode, light_pct, soil_pct, co2_ppm
  typedef struct packed {
    logic [4:0]  pad;
    logic [12:0] co2_ppm;
    logic [6:0]  soil_pct;
    logic [6:0]  light_pct;
    logic        manual_mode;
    logic [2:0]  menu_position;
    logic        buzzer_on;
    logic        pump_on;
    logic        fan_on;
    logic        lamp_on;
  } result_t;

endpackage

>>> sv/trc_convert.sv
// Sample conversion: light and soil ADC to percent, CO2 clamp.
module trc_convert (
  input  trc_pkg::item_t   item_i,
  output trc_pkg::sample_t sample_o
);
  import trc_pkg::*;

  logic [18:0] light_prod;
  logic [6:0]  light_pct;
  logic [12:0] soil_diff;
  logic [24:0] soil_prod;
  logic [8:0]  soil_raw;
  logic [6:0]  soil_pct;
  logic [12:0] co2_capped;

  // Scale light by 99/4096
  always_comb begin
    light_prod = {7'd0, item_i.light_adc} * {12'd0, LIGHT_GAIN};
    light_pct  = (light_prod[18:12] > PCT_MAX) ? PCT_MAX : light_prod[18:12];
  end

  // Invert and scale soil; wet below one volt reads full scale
  always_comb begin
    soil_diff = ADC_FULL - {1'b0, item_i.soil_adc};
    soil_prod = {12'd0, soil_diff} * {13'd0, SOIL_GAIN};
    soil_raw  = soil_prod[24:16];
    if (item_i.soil_adc <= SOIL_DRY_EDGE) begin
      soil_pct = PCT_MAX;
    end else if (soil_raw > {2'd0, PCT_MAX}) begin
      soil_pct = PCT_MAX;
    end else begin
      soil_pct = soil_raw[6:0];
    end
  end

  // Clamp the CO2 reading
  always_comb begin
    if (item_i.co2_reading > {1'b0, CO2_CAP}) begin
      co2_capped = CO2_CAP;
    end else begin
      co2_capped = item_i.co2_reading[12:0];
    end
  end

  assign sample_o.light_pct = light_pct;
  assign sample_o.soil_pct  = soil_pct;
  assign sample_o.temp_deg  = item_i.temp_deg;
  assign sample_o.co2_valid = item_i.co2_valid;
  assign sample_o.co2_ppm   = co2_capped;

endmodule

>>> sv/trc_ctrl.sv
// Menu, setpoint and relay state with its per-request update.
module trc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  trc_pkg::item_t       item_i,
  input  trc_pkg::sample_t     sample_i,
  output trc_pkg::ctrl_state_t state_d_o
);
  import trc_pkg::*;

  ctrl_state_t state_q;
  ctrl_state_t state_d;
  logic        dark;
  logic        hot;
  logic        dry;
  logic        gas;
  logic [12:0] co2_now;

  // Threshold checks on the fresh readings
  always_comb begin
    co2_now = sample_i.co2_valid ? sample_i.co2_ppm : state_q.co2_stored;
    dark    = sample_i.light_pct <= state_q.light_sp;
    hot     = sample_i.temp_deg >= {1'b0, state_q.temp_sp};
    gas     = co2_now >= state_q.co2_limit;
    dry     = sample_i.soil_pct <= state_q.moisture_sp;
  end

  // Work out the state after the request
  always_comb begin
    state_d = state_q;
    case (item_i.op)
      OP_MENU: begin
        state_d.buzzer   = 1'b0;
        state_d.menu_pos = (state_q.menu_pos >= MENU_MODE) ? MENU_RUN
                                                           : state_q.menu_pos + 3'd1;
      end
      OP_UP: begin
        case (state_q.menu_pos)
          MENU_RUN:   if (state_q.manual_flag) state_d.lamp = ~state_q.lamp;
          MENU_MOIST: if (state_q.moisture_sp < PCT_MAX) begin
            state_d.moisture_sp = state_q.moisture_sp + 7'd1;
          end
          MENU_TEMP:  if (state_q.temp_sp < PCT_MAX) begin
            state_d.temp_sp = state_q.temp_sp + 7'd1;
          end
          MENU_LIGHT: if (state_q.light_sp < PCT_MAX) begin
            state_d.light_sp = state_q.light_sp + 7'd1;
          end
          MENU_CO2:   if (state_q.co2_limit < CO2_CAP) begin
            state_d.co2_limit = state_q.co2_limit + CO2_STEP;
          end
          MENU_MODE:  state_d.manual_flag = 1'b0;
          default:    ;
        endcase
      end
      OP_DOWN: begin
        case (state_q.menu_pos)
          MENU_RUN:   if (state_q.manual_flag) state_d.fan = ~state_q.fan;
          MENU_MOIST: if (state_q.moisture_sp != 7'd0) begin
            state_d.moisture_sp = state_q.moisture_sp - 7'd1;
          end
          MENU_TEMP:  if (state_q.temp_sp != 7'd0) begin
            state_d.temp_sp = state_q.temp_sp - 7'd1;
          end
          MENU_LIGHT: if (state_q.light_sp != 7'd0) begin
            state_d.light_sp = state_q.light_sp - 7'd1;
          end
          MENU_CO2:   if (state_q.co2_limit >= CO2_STEP) begin
            state_d.co2_limit = state_q.co2_limit - CO2_STEP;
          end
          MENU_MODE:  state_d.manual_flag = 1'b1;
          default:    ;
        endcase
      end
      OP_PUMP: begin
        if (state_q.menu_pos == MENU_RUN && state_q.manual_flag) begin
          state_d.pump = ~state_q.pump;
        end
      end
      OP_SAMPLE: begin
        if (state_q.menu_pos == MENU_RUN) begin
          state_d.light_stored = sample_i.light_pct;
          state_d.soil_stored  = sample_i.soil_pct;
          state_d.co2_stored   = co2_now;
          if (!state_q.manual_flag) begin
            state_d.lamp   = dark;
            state_d.fan    = hot | gas;
            state_d.pump   = dry;
            state_d.buzzer = dark | hot | dry | gas;
          end else begin
            state_d.buzzer = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance the state once per request taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign state_d_o = state_d;

  a_menu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.menu_pos <= MENU_MODE)
    else $error("menu position out of range");

  a_pct_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.moisture_sp <= PCT_MAX && state_q.temp_sp <= PCT_MAX &&
    state_q.light_sp <= PCT_MAX)
    else $error("percent setpoint beyond limit");

  a_co2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.co2_limit <= CO2_CAP && state_q.co2_stored <= CO2_CAP)
    else $error("CO2 value beyond cap");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(state_q))
    else $error("state changed without a request");

endmodule

>>> sv/threshold_relay_controller_with_menu.sv
// Top level of the threshold relay controller: stream ports, input and result registers.
// Each request (key press or sample tick) gives one result word showing the
// relay, menu and reading state after that request. A request is taken into
// an input register; the state update and sample conversion are combinational
// between that register and the result register, so one request is taken
// every cycle while the master side keeps taking results. A held request
// moves into the result register once that slot is free or being emptied.
// The result register lets the next request enter while a result still
// waits on the master side.
module threshold_relay_controller_with_menu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: light_adc[11:0], soil_adc[23:12], temp_deg[31:24], co2_reading[45:32]
  input  logic [47:0] s_axis_tdata_i,
  // tuser: op[2:0], co2_valid[3]
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: lamp_on[0], fan_on[1], pump_on[2], buzzer_on[3], menu_position[6:4],
  //        manual_mode[7], light_pct[14:8], soil_pct[21:15], co2_ppm[34:22]
  output logic [39:0] m_axis_tdata_o
);
  import trc_pkg::*;

  item_t       in_item;
  item_t       in_item_q;
  logic        in_valid_q;
  logic        in_valid_d;
  logic        advance;
  logic        take;
  sample_t     sample;
  ctrl_state_t state_d;
  result_t     res_d;
  result_t     res_q;
  logic        out_valid_q;
  logic        out_valid_d;

  // Unpack the incoming request
  assign in_item.op          = op_e'(s_axis_tuser_i[2:0]);
  assign in_item.co2_valid   = s_axis_tuser_i[3];
  assign in_item.light_adc   = s_axis_tdata_i[11:0];
  assign in_item.soil_adc    = s_axis_tdata_i[23:12];
  assign in_item.temp_deg    = s_axis_tdata_i[31:24];
  assign in_item.co2_reading = s_axis_tdata_i[45:32];

  // Handshake: move the held request on whenever the result slot frees
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign take            = s_axis_tvalid_i & s_axis_tready_o;
  assign in_valid_d      = take | (in_valid_q & ~advance);
  assign out_valid_d     = advance | (out_valid_q & ~m_axis_tready_i);

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q <= in_item;
    end
  end

  trc_convert u_convert (
    .item_i   (in_item_q),
    .sample_o (sample)
  );

  trc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_item_q),
    .sample_i  (sample),
    .state_d_o (state_d)
  );

  // Build the result word from the updated state
  always_comb begin
    res_d.pad           = '0;
    res_d.co2_ppm       = state_d.co2_stored;
    res_d.soil_pct      = state_d.soil_stored;
    res_d.light_pct     = state_d.light_stored;
    res_d.manual_mode   = state_d.manual_flag;
    res_d.menu_position = state_d.menu_pos;
    res_d.buzzer_on     = state_d.buzzer;
    res_d.pump_on       = state_d.pump;
    res_d.fan_on        = state_d.fan;
    res_d.lamp_on       = state_d.lamp;
  end

  // Hold the result until the master side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

  a_advance_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("request moved on but no result offered");

  a_stall_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("held request lost during a stall");

  a_result_menu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.menu_position <= MENU_MODE)
    else $error("result menu position out of range");

endmodule

>>> verif/tb_top.sv
// Testbench for the threshold relay controller: directed and random requests, checked per result.
`timescale 1ns / 1ps

module tb_top;
  import trc_pkg::*;

  // Op codes past the sample tick, which the block ignores
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One request as the tests build it
  typedef struct packed {
    logic [2:0]  op;
    logic [11:0] light_adc;
    logic [11:0] soil_adc;
    logic [7:0]  temp_deg;
    logic        co2_valid;
    logic [13:0] co2_reading;
  } request_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tdata: light_adc[11:0], soil_adc[23:12], temp_deg[31:24], co2_reading[45:32]
  logic [47:0] s_axis_tdata_i  = '0;
  // tuser: op[2:0], co2_valid[3]
  logic [3:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // tdata: lamp_on[0], fan_on[1], pump_on[2], buzzer_on[3], menu_position[6:4],
  //        manual_mode[7], light_pct[14:8], soil_pct[21:15], co2_ppm[34:22]
  logic [39:0] m_axis_tdata_o;

  ctrl_state_t ctrl_model = STATE_RESET;
  result_t     status_q[$];
  int unsigned mismatch_count     = 0;
  int unsigned live_requests      = 0;
  int unsigned cycle_count        = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  threshold_relay_controller_with_menu i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Clock generation
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Apply one request to the controller state and return the status it reports
  function automatic result_t advance_controller(input request_t r);
    int unsigned light_v;
    int unsigned soil_v;
    int unsigned co2_v;
    logic        dark, hot, dry, gas;
    result_t     res;
    case (r.op)
      OP_MENU: begin
        ctrl_model.buzzer   = 1'b0;
        ctrl_model.menu_pos = (ctrl_model.menu_pos >= MENU_MODE) ? MENU_RUN
                                                                 : ctrl_model.menu_pos + 3'd1;
      end
      OP_UP: begin
        if (ctrl_model.menu_pos == MENU_RUN && ctrl_model.manual_flag) begin
          ctrl_model.lamp = ~ctrl_model.lamp;
        end else if (ctrl_model.menu_pos == MENU_MOIST) begin
          if (ctrl_model.moisture_sp < PCT_MAX) ctrl_model.moisture_sp++;
        end else if (ctrl_model.menu_pos == MENU_TEMP) begin
          if (ctrl_model.temp_sp < PCT_MAX) ctrl_model.temp_sp++;
        end else if (ctrl_model.menu_pos == MENU_LIGHT) begin
          if (ctrl_model.light_sp < PCT_MAX) ctrl_model.light_sp++;
        end else if (ctrl_model.menu_pos == MENU_CO2) begin
          if (ctrl_model.co2_limit < CO2_CAP) ctrl_model.co2_limit += CO2_STEP;
        end else if (ctrl_model.menu_pos == MENU_MODE) begin
          ctrl_model.manual_flag = 1'b0;
        end
      end
      OP_DOWN: begin
        if (ctrl_model.menu_pos == MENU_RUN && ctrl_model.manual_flag) begin
          ctrl_model.fan = ~ctrl_model.fan;
        end else if (ctrl_model.menu_pos == MENU_MOIST) begin
          if (ctrl_model.moisture_sp > 0) ctrl_model.moisture_sp--;
        end else if (ctrl_model.menu_pos == MENU_TEMP) begin
          if (ctrl_model.temp_sp > 0) ctrl_model.temp_sp--;
        end else if (ctrl_model.menu_pos == MENU_LIGHT) begin
          if (ctrl_model.light_sp > 0) ctrl_model.light_sp--;
        end else if (ctrl_model.menu_pos == MENU_CO2) begin
          if (ctrl_model.co2_limit >= CO2_STEP) ctrl_model.co2_limit -= CO2_STEP;
        end else if (ctrl_model.menu_pos == MENU_MODE) begin
          ctrl_model.manual_flag = 1'b1;
        end
      end
      OP_PUMP: begin
        if (ctrl_model.menu_pos == MENU_RUN && ctrl_model.manual_flag) begin
          ctrl_model.pump = ~ctrl_model.pump;
        end
      end
      OP_SAMPLE: begin
        if (ctrl_model.menu_pos == MENU_RUN) begin
          // Convert the readings to percentages
          light_v = (int'(r.light_adc) * int'(LIGHT_GAIN)) >> 12;
          if (light_v > PCT_MAX) light_v = PCT_MAX;
          if (r.soil_adc <= SOIL_DRY_EDGE) begin
            soil_v = PCT_MAX;
          end else begin
            soil_v = ((int'(ADC_FULL) - int'(r.soil_adc)) * int'(SOIL_GAIN)) >> 16;
            if (soil_v > PCT_MAX) soil_v = PCT_MAX;
          end
          ctrl_model.light_stored = 7'(light_v);
          ctrl_model.soil_stored  = 7'(soil_v);
          // Hold a new CO2 reading, capped
          if (r.co2_valid) begin
            co2_v = r.co2_reading;
            ctrl_model.co2_stored = (co2_v > CO2_CAP) ? CO2_CAP : 13'(co2_v);
          end
          // Drive relays by threshold in automatic mode, else silence the buzzer
          if (!ctrl_model.manual_flag) begin
            dark = ctrl_model.light_stored <= ctrl_model.light_sp;
            hot  = int'(r.temp_deg) >= int'(ctrl_model.temp_sp);
            gas  = ctrl_model.co2_stored >= ctrl_model.co2_limit;
            dry  = ctrl_model.soil_stored <= ctrl_model.moisture_sp;
            ctrl_model.lamp   = dark;
            ctrl_model.fan    = hot || gas;
            ctrl_model.pump   = dry;
            ctrl_model.buzzer = dark || hot || dry || gas;
          end else begin
            ctrl_model.buzzer = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res               = '0;
    res.lamp_on       = ctrl_model.lamp;
    res.fan_on        = ctrl_model.fan;
    res.pump_on       = ctrl_model.pump;
    res.buzzer_on     = ctrl_model.buzzer;
    res.menu_position = ctrl_model.menu_pos;
    res.manual_mode   = ctrl_model.manual_flag;
    res.light_pct     = ctrl_model.light_stored;
    res.soil_pct      = ctrl_model.soil_stored;
    res.co2_ppm       = ctrl_model.co2_stored;
    return res;
  endfunction

  // True when the request can change something in the current state
  function automatic logic has_effect(input request_t r);
    case (r.op)
      OP_MENU:         return 1'b1;
      OP_UP, OP_DOWN:  return ctrl_model.menu_pos != MENU_RUN || ctrl_model.manual_flag;
      OP_PUMP:         return ctrl_model.menu_pos == MENU_RUN && ctrl_model.manual_flag;
      OP_SAMPLE:       return ctrl_model.menu_pos == MENU_RUN;
      default:         return 1'b0;
    endcase
  endfunction

  // Send one request, idling first at random; predict its status on acceptance
  task automatic send_request(input request_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, r.co2_reading, r.temp_deg, r.soil_adc, r.light_adc};
    s_axis_tuser_i  <= {r.co2_valid, r.op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (has_effect(r)) live_requests++;
    status_q.push_back(advance_controller(r));
  endtask

  // Every field random, op as given
  function automatic request_t random_request(input logic [2:0] op);
    request_t r;
    r.op          = op;
    r.light_adc   = 12'($urandom);
    r.soil_adc    = 12'($urandom);
    r.temp_deg    = 8'($urandom);
    r.co2_valid   = 1'($urandom);
    r.co2_reading = 14'($urandom);
    return r;
  endfunction

  // Sample tick with readings biased towards the thresholds and extremes
  function automatic request_t sample_request();
    request_t    r;
    int unsigned lim;
    r = random_request(OP_SAMPLE);
    case ($urandom_range(0, 9))
      0:       r.light_adc = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      1, 2, 3: r.light_adc = 12'($urandom_range(0, 1000));
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       r.soil_adc = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      1, 2:    r.soil_adc = 12'($urandom_range(1230, 1250));
      3, 4:    r.soil_adc = 12'($urandom_range(3700, 4095));
      default: ;
    endcase
    if ($urandom_range(0, 1)) r.temp_deg = 8'($urandom_range(0, 70));
    lim = ctrl_model.co2_limit;
    case ($urandom_range(0, 9))
      0:       ;
      1, 2:    r.co2_reading = 14'($urandom_range(lim + 30, (lim >= 30) ? lim - 30 : 0));
      default: r.co2_reading = 14'($urandom_range(0, 9999));
    endcase
    return r;
  endfunction

  // Step the menu until it stands at the wanted position
  task automatic goto_menu(input logic [2:0] pos);
    while (ctrl_model.menu_pos != pos) send_request(random_request(OP_MENU));
  endtask

  // Wait until every status has arrived, then a drain interval for strays
  task automatic wait_until_drained();
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Readings at their extremes, the soil edge, no new CO2, unused ops, a pump request
  task automatic test_sample_extremes();
    request_t r;
    r = random_request(OP_SAMPLE);
    r.light_adc = '0; r.soil_adc = '0; r.temp_deg = '0;
    r.co2_valid = 1'b1; r.co2_reading = '0;
    send_request(r);
    r.light_adc = '1; r.soil_adc = '1; r.temp_deg = '1;
    r.co2_valid = 1'b1; r.co2_reading = '1;
    send_request(r);
    r.soil_adc = SOIL_DRY_EDGE; r.co2_valid = 1'b0; r.co2_reading = 14'd9999;
    send_request(r);
    r.soil_adc = SOIL_DRY_EDGE + 12'd1; r.temp_deg = 8'd35; r.co2_valid = 1'b1;
    r.co2_reading = 14'd5001;
    send_request(r);
    send_request(random_request(OP_UNUSED_FIRST));
    send_request(random_request(OP_UNUSED_LAST));
    send_request(random_request(OP_PUMP));
  endtask

  // Walk the menu, nudge each setpoint, sample away from the run position
  task automatic test_menu_setpoints();
    send_request(random_request(OP_MENU));
    send_request(sample_request());
    send_request(random_request(OP_UP));
    send_request(random_request(OP_DOWN));
    send_request(random_request(OP_MENU));
    send_request(random_request(OP_UP));
    send_request(random_request(OP_DOWN));
    send_request(random_request(OP_MENU));
    send_request(random_request(OP_DOWN));
    send_request(random_request(OP_MENU));
    send_request(random_request(OP_UP));
    send_request(random_request(OP_DOWN));
    send_request(random_request(OP_MENU));
    send_request(random_request(OP_DOWN));
    send_request(random_request(OP_MENU));
  endtask

  // Toggle the relays by hand, then sample in manual mode
  task automatic test_manual_relays();
    send_request(random_request(OP_UP));
    send_request(random_request(OP_DOWN));
    send_request(random_request(OP_PUMP));
    send_request(sample_request());
  endtask

  // Random sequences of menu walks, setpoint sweeps, mode changes, samples and noise
  task automatic test_random_traffic(input int unsigned idle_pct, stall_pct, count);
    int unsigned goal;
    int unsigned pick;
    logic [2:0]  pos;
    logic        go_up;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    goal = live_requests + count;
    while (live_requests < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        goto_menu(MENU_RUN);
        repeat ($urandom_range(1, 8)) send_request(sample_request());
      end else if (pick < 70) begin
        pos = 3'($urandom_range(MENU_MOIST, MENU_CO2));
        goto_menu(pos);
        if ($urandom_range(0, (pos == MENU_CO2) ? 19 : 9) == 0) begin
          // Long sweep in one direction to reach the saturation limits
          go_up = 1'($urandom);
          repeat ((pos == MENU_CO2) ? $urandom_range(150, 320) : $urandom_range(30, 110))
            send_request(random_request(go_up ? OP_UP : OP_DOWN));
        end else begin
          repeat ($urandom_range(1, 10))
            send_request(random_request($urandom_range(0, 1) ? OP_UP : OP_DOWN));
        end
      end else if (pick < 80) begin
        goto_menu(MENU_MODE);
        send_request(random_request($urandom_range(0, 1) ? OP_UP : OP_DOWN));
      end else if (pick < 90) begin
        goto_menu(MENU_RUN);
        repeat ($urandom_range(1, 4))
          send_request(random_request(3'($urandom_range(OP_UP, OP_PUMP))));
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(random_request(3'($urandom_range(OP_MENU, OP_UNUSED_LAST))));
      end
    end
  endtask

  // Compare a single status field
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Check each accepted status against the oldest prediction
  always @(posedge clk_i) begin : check_status
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o);
      if (status_q.size() == 0) begin
        $error("status with no request pending: %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = status_q.pop_front();
        check_field("lamp_on", want.lamp_on, got.lamp_on);
        check_field("fan_on", want.fan_on, got.fan_on);
        check_field("pump_on", want.pump_on, got.pump_on);
        check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
        check_field("menu_position", want.menu_position, got.menu_position);
        check_field("manual_mode", want.manual_mode, got.manual_mode);
        check_field("light_pct", want.light_pct, got.light_pct);
        check_field("soil_pct", want.soil_pct, got.soil_pct);
        check_field("co2_ppm", want.co2_ppm, got.co2_ppm);
      end
    end
  end

  // Reset, run the tests in turn, report
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_sample_extremes();
    test_menu_setpoints();
    test_manual_relays();
    test_random_traffic(0, 0, 420);
    test_random_traffic(63, 0, 420);
    test_random_traffic(0, 63, 420);
    test_random_traffic(23, 23, 420);
    s_axis_tvalid_i <= 1'b0;
    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
